FILE: sv/ymb_pkg.sv
// Shared types, codes and the CRC-16 step for the YMODEM block receiver.
// No dependencies; imported by every module of the block.
package ymb_pkg;

  localparam int RES_MAX = 3;

  // Input event codes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_BYTE    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // Link bytes
  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_NAK  = 8'h15;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_C    = 8'h43;
  localparam logic [7:0] B_ZERO = 8'h30;
  localparam logic [7:0] B_NINE = 8'h39;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic CFG_BUFFER_LIMIT = 1'b0;
  localparam logic CFG_RETRY_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    K_TX     = 3'd0,
    K_DATA   = 3'd1,
    K_NAME   = 3'd2,
    K_BLOCK  = 3'd3,
    K_FINISH = 3'd4
  } kind_t;

  // All result words caused by one input item
  typedef struct packed {
    logic [1:0]                n;
    kind_t [RES_MAX-1:0]       kinds;
    logic [RES_MAX-1:0][7:0]   bytes;
    logic [23:0]               address;
    logic [24:0]               count;
    logic [31:0]               fsize;
    logic                      status;
  } bundle_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/ymb_core.sv
// Protocol state and per-item result computation for the YMODEM receiver.
// Depends on ymb_pkg. One registered input item is processed per step.
module ymb_core
  import ymb_pkg::*;
#(
  parameter int ADDRESS_BITS = 24,
  parameter int NAME_LIMIT   = 256,
  parameter int SIZE_DIGITS  = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [24:0] buffer_limit,
  input  logic [7:0]  retry_limit,
  output bundle_t     res
);

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HEADER = 8'b0000_0010,
    PH_SEQ    = 8'b0000_0100,
    PH_SEQC   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_CRCH   = 8'b0010_0000,
    PH_CRCL   = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  localparam logic [1:0] ST_NAME = 2'd0;
  localparam logic [1:0] ST_SIZE = 2'd1;
  localparam logic [1:0] ST_END  = 2'd3;

  localparam logic [23:0] ADDR_MASK = (ADDRESS_BITS >= 24) ? 24'hFF_FFFF :
                                      24'((64'd1 << ADDRESS_BITS) - 64'd1);

  phase_t      phase, phase_next;
  logic        long_block, long_block_next;
  logic [7:0]  expected_seq, expected_seq_next;
  logic [7:0]  received_seq, received_seq_next;
  logic [10:0] byte_index, byte_index_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_msb, crc_msb_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [24:0] committed, committed_next;
  logic        info_received, info_received_next;
  logic [1:0]  info_stage, info_stage_next;
  logic [31:0] size_acc, size_acc_next;
  logic [3:0]  digit_count, digit_count_next;

  logic [10:0] blk_len;
  logic [10:0] byte_index_inc;
  logic [25:0] addr_sum;
  logic [24:0] room;
  logic [24:0] take_len;
  logic [24:0] commit_sum;
  logic [7:0]  retry_inc;
  logic [31:0] size_step;
  logic        non_digit;

  assign blk_len        = long_block ? 11'd1024 : 11'd128;
  assign byte_index_inc = byte_index + 11'd1;
  assign addr_sum       = {1'b0, committed} + 26'(byte_index);
  assign room           = (buffer_limit > committed) ? (buffer_limit - committed) : 25'd0;
  assign take_len       = (25'(blk_len) > room) ? room : 25'(blk_len);
  assign commit_sum     = committed + take_len;
  assign retry_inc      = retry_count + 8'd1;
  assign size_step      = (size_acc << 3) + (size_acc << 1) + 32'(rx_byte - B_ZERO);
  assign non_digit      = (rx_byte < B_ZERO) || (rx_byte > B_NINE);

  always_comb begin
    logic [1:0] cnt;
    logic       fail_hit;
    logic       good_hit;

    phase_next         = phase;
    long_block_next    = long_block;
    expected_seq_next  = expected_seq;
    received_seq_next  = received_seq;
    byte_index_next    = byte_index;
    running_crc_next   = running_crc;
    crc_msb_next       = crc_msb;
    retry_count_next   = retry_count;
    committed_next     = committed;
    info_received_next = info_received;
    info_stage_next    = info_stage;
    size_acc_next      = size_acc;
    digit_count_next   = digit_count;
    res                = '0;
    cnt                = 2'd0;
    fail_hit           = 1'b0;
    good_hit           = 1'b0;

    if (mode == MODE_START) begin
      phase_next         = PH_HEADER;
      long_block_next    = 1'b0;
      expected_seq_next  = 8'd0;
      received_seq_next  = 8'd0;
      byte_index_next    = 11'd0;
      running_crc_next   = 16'd0;
      crc_msb_next       = 8'd0;
      retry_count_next   = 8'd0;
      committed_next     = 25'd0;
      info_received_next = 1'b0;
      info_stage_next    = ST_NAME;
      size_acc_next      = 32'd0;
      digit_count_next   = 4'd0;
      res.kinds[cnt] = K_TX;
      res.bytes[cnt] = B_C;
      cnt = cnt + 2'd1;
    end else if (mode == MODE_NONE || phase == PH_IDLE || phase == PH_DONE) begin
      // drop the event
    end else if (mode == MODE_TIMEOUT) begin
      fail_hit = 1'b1;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (rx_byte == B_EOT) begin
            res.kinds[cnt] = K_TX;
            res.bytes[cnt] = B_ACK;
            cnt = cnt + 2'd1;
            res.kinds[cnt] = K_FINISH;
            cnt = cnt + 2'd1;
            phase_next = PH_DONE;
          end else if (rx_byte == B_SOH || rx_byte == B_STX) begin
            long_block_next = (rx_byte == B_STX);
            phase_next      = PH_SEQ;
          end else begin
            fail_hit = 1'b1;
          end
        end
        PH_SEQ: begin
          received_seq_next = rx_byte;
          phase_next        = PH_SEQC;
        end
        PH_SEQC: begin
          if (received_seq != ~rx_byte ||
              (expected_seq != 8'd0 && received_seq != expected_seq)) begin
            fail_hit = 1'b1;
          end else begin
            byte_index_next  = 11'd0;
            running_crc_next = 16'd0;
            if (!info_received) begin
              info_stage_next  = ST_NAME;
              size_acc_next    = 32'd0;
              digit_count_next = 4'd0;
            end
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          running_crc_next = crc16_step(running_crc, rx_byte);
          if (info_received) begin
            if (addr_sum < {1'b0, buffer_limit}) begin
              res.kinds[cnt] = K_DATA;
              res.bytes[cnt] = rx_byte;
              res.address    = addr_sum[23:0] & ADDR_MASK;
              cnt = cnt + 2'd1;
            end
          end else if (received_seq == 8'd0) begin
            if (info_stage == ST_NAME) begin
              if (rx_byte == 8'd0 || byte_index >= 11'(NAME_LIMIT)) begin
                info_stage_next = ST_SIZE;
              end else begin
                res.kinds[cnt] = K_NAME;
                res.bytes[cnt] = rx_byte;
                res.address    = 24'(byte_index);
                cnt = cnt + 2'd1;
              end
            end else if (info_stage == ST_SIZE) begin
              if (rx_byte == 8'd0 || digit_count >= 4'(SIZE_DIGITS) || non_digit) begin
                info_stage_next = ST_END;
              end else begin
                size_acc_next    = size_step;
                digit_count_next = digit_count + 4'd1;
              end
            end
          end
          byte_index_next = byte_index_inc;
          if (byte_index_inc >= blk_len) begin
            phase_next = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_msb_next = rx_byte;
          phase_next   = PH_CRCL;
        end
        PH_CRCL: begin
          if ({crc_msb, rx_byte} == running_crc) begin
            good_hit = 1'b1;
          end else begin
            fail_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (fail_hit) begin
      retry_count_next = retry_inc;
      phase_next       = PH_HEADER;
      if (retry_inc >= retry_limit) begin
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = B_CAN;
        cnt = cnt + 2'd1;
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = B_CAN;
        cnt = cnt + 2'd1;
        res.kinds[cnt] = K_FINISH;
        cnt = cnt + 2'd1;
        res.status = 1'b1;
        phase_next = PH_DONE;
      end else begin
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = info_received ? B_NAK : B_C;
        cnt = cnt + 2'd1;
      end
    end

    if (good_hit) begin
      retry_count_next = 8'd0;
      phase_next       = PH_HEADER;
      if (!info_received) begin
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = B_ACK;
        cnt = cnt + 2'd1;
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = B_C;
        cnt = cnt + 2'd1;
        // header block: take the info; any other number is acked and dropped
        if (received_seq == 8'd0) begin
          info_received_next = 1'b1;
          expected_seq_next  = 8'd1;
          res.kinds[cnt] = K_BLOCK;
          cnt = cnt + 2'd1;
        end
      end else begin
        committed_next    = commit_sum;
        expected_seq_next = expected_seq + 8'd1;
        res.kinds[cnt] = K_TX;
        res.bytes[cnt] = B_ACK;
        cnt = cnt + 2'd1;
        res.kinds[cnt] = K_BLOCK;
        cnt = cnt + 2'd1;
        if (commit_sum >= buffer_limit) begin
          res.kinds[cnt] = K_FINISH;
          cnt = cnt + 2'd1;
          phase_next = PH_DONE;
        end
      end
    end

    res.n     = cnt;
    res.count = committed_next;
    res.fsize = info_received_next ? size_acc : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      long_block    <= 1'b0;
      expected_seq  <= 8'd0;
      received_seq  <= 8'd0;
      byte_index    <= 11'd0;
      running_crc   <= 16'd0;
      crc_msb       <= 8'd0;
      retry_count   <= 8'd0;
      committed     <= 25'd0;
      info_received <= 1'b0;
      info_stage    <= ST_NAME;
      size_acc      <= 32'd0;
      digit_count   <= 4'd0;
    end else if (step) begin
      phase         <= phase_next;
      long_block    <= long_block_next;
      expected_seq  <= expected_seq_next;
      received_seq  <= received_seq_next;
      byte_index    <= byte_index_next;
      running_crc   <= running_crc_next;
      crc_msb       <= crc_msb_next;
      retry_count   <= retry_count_next;
      committed     <= committed_next;
      info_received <= info_received_next;
      info_stage    <= info_stage_next;
      size_acc      <= size_acc_next;
      digit_count   <= digit_count_next;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= 11'd1024)
    else $error("byte index past the longest block");

  a_long_block_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && !long_block) |-> byte_index < 11'd128)
    else $error("short block ran past 128 bytes");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register not one-hot");

endmodule

FILE: sv/ymb_out.sv
// Two-deep queue of result bundles and the serializer that sends their words.
// Depends on ymb_pkg.
module ymb_out
  import ymb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bundle_t     push_b,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic [23:0] address,
  output logic [24:0] received_count,
  output logic [31:0] parsed_size,
  output logic        status,
  output logic        last
);

  bundle_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic [1:0] idx;
  bundle_t    head;
  kind_t      hk;
  logic       word_done;
  logic       pop;

  assign ready     = (used != 2'd2);
  assign out_valid = (used != 2'd0);
  assign head      = q[rd_ptr];
  assign hk        = head.kinds[idx];
  assign last      = (idx == head.n - 2'd1);
  assign word_done = out_valid && out_ready;
  assign pop       = word_done && last;

  assign kind           = hk;
  assign out_byte       = (hk == K_TX || hk == K_DATA || hk == K_NAME) ? head.bytes[idx] : 8'd0;
  assign address        = (hk == K_DATA || hk == K_NAME) ? head.address : 24'd0;
  assign received_count = (hk == K_BLOCK || hk == K_FINISH) ? head.count : 25'd0;
  assign parsed_size    = (hk == K_BLOCK || hk == K_FINISH) ? head.fsize : 32'd0;
  assign status         = (hk == K_FINISH) ? head.status : 1'b0;

  always_ff @(posedge clk) begin
    if (push && ready) begin
      q[wr_ptr] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (push && ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= 2'd0;
      end else if (word_done) begin
        idx <= idx + 2'd1;
      end
      used <= used + 2'((push && ready) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
  end

  a_no_empty_push: assert property (@(posedge clk) disable iff (rst)
    push |-> push_b.n != 2'd0)
    else $error("empty bundle pushed");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    used <= 2'd2)
    else $error("bundle queue overfilled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(idx) && $stable(rd_ptr))
    else $error("serializer moved during stall");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx < head.n)
    else $error("word index beyond bundle size");

endmodule

FILE: sv/ymodem_block_receiver.sv
// YMODEM block receiver, CRC-16 mode. An input word is one link event: start a session,
// a received byte, or a byte timeout. It enters an input register; from there the protocol
// state is updated and all result words of that event (none to three) are placed in a
// two-deep result queue in one step, which waits for room in the queue if the event has
// result words. The input side takes one event per cycle while that step is not held up;
// one result word leaves the queue per cycle while out_ready is high.
// Configuration: index 0 buffer_limit (reset 65536), index 1 retry_limit (reset 10).
// Depends on ymb_pkg, ymb_core and ymb_out.
module ymodem_block_receiver
  import ymb_pkg::*;
#(
  parameter int ADDRESS_BITS = 24,
  parameter int NAME_LIMIT   = 256,
  parameter int SIZE_DIGITS  = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic [23:0] address,
  output logic [24:0] received_count,
  output logic [31:0] parsed_size,
  output logic        status,
  output logic        last
);

  logic [24:0] buffer_limit;
  logic [7:0]  retry_limit;
  logic        in_full;
  logic [1:0]  in_mode;
  logic [7:0]  in_byte;
  logic        step;
  logic        q_ready;
  bundle_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= 25'd65536;
      retry_limit  <= 8'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BUFFER_LIMIT: buffer_limit <= cfg_data;
        CFG_RETRY_LIMIT:  retry_limit  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Step when the event has no result, or the queue has room for its bundle
  assign step     = in_full && (res.n == 2'd0 || q_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode <= mode;
      in_byte <= rx_byte;
    end
  end

  ymb_core #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .NAME_LIMIT   (NAME_LIMIT),
    .SIZE_DIGITS  (SIZE_DIGITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .mode         (in_mode),
    .rx_byte      (in_byte),
    .buffer_limit (buffer_limit),
    .retry_limit  (retry_limit),
    .res          (res)
  );

  ymb_out u_out (
    .clk            (clk),
    .rst            (rst),
    .push           (step && res.n != 2'd0),
    .push_b         (res),
    .ready          (q_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_byte       (out_byte),
    .address        (address),
    .received_count (received_count),
    .parsed_size    (parsed_size),
    .status         (status),
    .last           (last)
  );

endmodule

FILE: tb/tb_ymodem_block_receiver.sv
// Self-checking testbench for ymodem_block_receiver: directed and random YMODEM link traffic.
// Predicts every result word in-house and compares each accepted word in order.
// Depends on ymb_pkg and the ymodem_block_receiver RTL.
`timescale 1ns / 100ps

module tb_ymodem_block_receiver
  import ymb_pkg::*;
;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          NAME_CHARS    = 256;
  localparam int          SIZE_CHARS    = 15;
  localparam logic [24:0] BUF_LIMIT_MAX = 25'h1000000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_SEQ, PH_SEQC, PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_DONE
  } link_phase_t;

  typedef enum logic [1:0] {
    INFO_NAME = 2'd0,
    INFO_SIZE = 2'd1,
    INFO_REST = 2'd3
  } info_stage_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] addr;
    logic [24:0] count;
    logic [31:0] fsize;
    logic        stat;
    logic        is_last;
  } result_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [24:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [23:0] address;
  logic [24:0] received_count;
  logic [31:0] parsed_size;
  logic        status;
  logic        last;

  ymodem_block_receiver #(
    .ADDRESS_BITS(24),
    .NAME_LIMIT(NAME_CHARS),
    .SIZE_DIGITS(SIZE_CHARS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .out_byte(out_byte),
    .address(address),
    .received_count(received_count),
    .parsed_size(parsed_size),
    .status(status),
    .last(last)
  );

  // Receiver model state and register copies
  logic [24:0]  limit_bytes;
  logic [7:0]   limit_retries;
  link_phase_t  rx_phase;
  logic         long_frame;
  logic [7:0]   seq_expected;
  logic [7:0]   seq_received;
  int unsigned  frame_index;
  logic [15:0]  frame_crc;
  logic [7:0]   crc_upper;
  logic [7:0]   failure_count;
  logic [24:0]  committed_bytes;
  logic         info_done;
  info_stage_t  info_stage;
  logic [31:0]  size_value;
  int unsigned  size_digits;

  result_word_t event_words[$];
  result_word_t expected_words[$];

  logic [7:0] payload [0:1023];
  logic       tx_idle_on;
  logic       rx_idle_on;
  int         hold_left = 0;
  int         events_sent = 0;
  int         words_checked = 0;
  int         mismatches = 0;
  int         sessions_run = 0;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_words.size());
      $display("simulation failed");
      $finish;
    end
  end

  // CRC-16, poly 0x1021, one bit at a time, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ d[k]) r = {r[14:0], 1'b0} ^ CRC_POLY;
      else r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void queue_word(input kind_t k, input logic [7:0] d, input logic [23:0] a,
                                     input logic [24:0] c, input logic [31:0] f,
                                     input logic st);
    result_word_t w;
    w.kind = k;
    w.data = d;
    w.addr = a;
    w.count = c;
    w.fsize = f;
    w.stat = st;
    w.is_last = 1'b0;
    event_words.push_back(w);
  endfunction

  function automatic logic [31:0] reported_size();
    return info_done ? size_value : 32'd0;
  endfunction

  function automatic void clear_session();
    rx_phase = PH_IDLE;
    long_frame = 1'b0;
    seq_expected = 8'd0;
    seq_received = 8'd0;
    frame_index = 0;
    frame_crc = 16'h0000;
    crc_upper = 8'd0;
    failure_count = 8'd0;
    committed_bytes = 25'd0;
    info_done = 1'b0;
    info_stage = INFO_NAME;
    size_value = 32'd0;
    size_digits = 0;
  endfunction

  function automatic void count_failure();
    failure_count = failure_count + 8'd1;
    rx_phase = PH_HEADER;
    if (failure_count >= limit_retries) begin
      queue_word(K_TX, B_CAN, 24'd0, 25'd0, 32'd0, 1'b0);
      queue_word(K_TX, B_CAN, 24'd0, 25'd0, 32'd0, 1'b0);
      queue_word(K_FINISH, 8'd0, 24'd0, committed_bytes, reported_size(), 1'b1);
      rx_phase = PH_DONE;
    end else begin
      queue_word(K_TX, info_done ? B_NAK : B_C, 24'd0, 25'd0, 32'd0, 1'b0);
    end
  endfunction

  // Block 0 payload: filename up to a zero byte, then decimal size digits
  function automatic void take_info_byte(input logic [7:0] b);
    if (info_stage == INFO_NAME) begin
      if (b == 8'h00 || frame_index >= NAME_CHARS) info_stage = INFO_SIZE;
      else queue_word(K_NAME, b, 24'(frame_index), 25'd0, 32'd0, 1'b0);
    end else if (info_stage == INFO_SIZE) begin
      if (b == 8'h00 || size_digits >= SIZE_CHARS || b < B_ZERO || b > B_NINE) begin
        info_stage = INFO_REST;
      end else begin
        size_value = size_value * 32'd10 + 32'(b - B_ZERO);
        size_digits++;
      end
    end
  endfunction

  function automatic void accept_block();
    int unsigned take;
    int unsigned room;
    take = long_frame ? 1024 : 128;
    failure_count = 8'd0;
    rx_phase = PH_HEADER;
    if (!info_done) begin
      queue_word(K_TX, B_ACK, 24'd0, 25'd0, 32'd0, 1'b0);
      queue_word(K_TX, B_C, 24'd0, 25'd0, 32'd0, 1'b0);
      if (seq_received == 8'd0) begin
        info_done = 1'b1;
        seq_expected = 8'd1;
        queue_word(K_BLOCK, 8'd0, 24'd0, committed_bytes, reported_size(), 1'b0);
      end
      return;
    end
    room = (limit_bytes > committed_bytes) ? limit_bytes - committed_bytes : 0;
    if (take > room) take = room;
    committed_bytes = committed_bytes + 25'(take);
    seq_expected = seq_expected + 8'd1;
    queue_word(K_TX, B_ACK, 24'd0, 25'd0, 32'd0, 1'b0);
    queue_word(K_BLOCK, 8'd0, 24'd0, committed_bytes, reported_size(), 1'b0);
    if (committed_bytes >= limit_bytes) begin
      queue_word(K_FINISH, 8'd0, 24'd0, committed_bytes, reported_size(), 1'b0);
      rx_phase = PH_DONE;
    end
  endfunction

  function automatic void predict_link_event(input logic [1:0] m, input logic [7:0] b);
    int unsigned       frame_len;
    longint unsigned   waddr;
    result_word_t      w;
    event_words.delete();
    frame_len = long_frame ? 1024 : 128;
    if (m == MODE_START) begin
      clear_session();
      rx_phase = PH_HEADER;
      queue_word(K_TX, B_C, 24'd0, 25'd0, 32'd0, 1'b0);
    end else if (m == MODE_NONE || rx_phase == PH_IDLE || rx_phase == PH_DONE) begin
      // no effect
    end else if (m == MODE_TIMEOUT) begin
      count_failure();
    end else begin
      case (rx_phase)
        PH_HEADER: begin
          if (b == B_EOT) begin
            queue_word(K_TX, B_ACK, 24'd0, 25'd0, 32'd0, 1'b0);
            queue_word(K_FINISH, 8'd0, 24'd0, committed_bytes, reported_size(), 1'b0);
            rx_phase = PH_DONE;
          end else if (b == B_SOH || b == B_STX) begin
            long_frame = (b == B_STX);
            rx_phase = PH_SEQ;
          end else begin
            count_failure();
          end
        end
        PH_SEQ: begin
          seq_received = b;
          rx_phase = PH_SEQC;
        end
        PH_SEQC: begin
          if ((seq_received ^ b) != 8'hFF ||
              (seq_expected != 8'd0 && seq_received != seq_expected)) begin
            count_failure();
          end else begin
            frame_index = 0;
            frame_crc = 16'h0000;
            if (!info_done) begin
              info_stage = INFO_NAME;
              size_value = 32'd0;
              size_digits = 0;
            end
            rx_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          frame_crc = crc_update(frame_crc, b);
          if (info_done) begin
            waddr = longint'(committed_bytes) + frame_index;
            // written speculatively, before the CRC is known
            if (waddr < limit_bytes) queue_word(K_DATA, b, waddr[23:0], 25'd0, 32'd0, 1'b0);
          end else if (seq_received == 8'd0) begin
            take_info_byte(b);
          end
          frame_index++;
          if (frame_index >= frame_len) rx_phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_upper = b;
          rx_phase = PH_CRC_LO;
        end
        default: begin
          if ({crc_upper, b} == frame_crc) accept_block();
          else count_failure();
        end
      endcase
    end
    for (int i = 0; i < event_words.size(); i++) begin
      w = event_words[i];
      w.is_last = (i == event_words.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  // Result side: random stalls, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin : check_words
    result_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word at %0t: kind %0d byte %h addr %h", $time, kind,
                   out_byte, address);
      end else begin
        want = expected_words.pop_front();
        if (kind !== want.kind || out_byte !== want.data || address !== want.addr ||
            received_count !== want.count || parsed_size !== want.fsize ||
            status !== want.stat || last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected kind %0d byte %h addr %h count %0d size %0d",
                     $time, want.kind, want.data, want.addr, want.count, want.fsize,
                     " status %b last %b", want.stat, want.is_last);
            $display("  actual kind %0d byte %h addr %h count %0d size %0d status %b last %b",
                     kind, out_byte, address, received_count, parsed_size, status, last);
          end
        end
      end
    end
  end

  task automatic send_event(input logic [1:0] m, input logic [7:0] b);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(99) < 24) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    events_sent++;
    predict_link_event(m, b);
  endtask

  // Drop valid, drain every expected word, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [24:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_BUFFER_LIMIT) limit_bytes = val;
    else limit_retries = val[7:0];
  endtask

  task automatic fill_random_payload();
    for (int i = 0; i < 1024; i++) payload[i] = 8'($urandom);
  endtask

  // Filename of name_len nonzero chars, a zero, then digit_count random digits
  task automatic fill_info_payload(input int name_len, input int digit_count);
    int pos;
    fill_random_payload();
    for (int i = 0; i < name_len; i++) payload[i] = 8'($urandom_range(255, 1));
    pos = name_len;
    payload[pos] = 8'h00;
    for (int i = 0; i < digit_count; i++) payload[pos + 1 + i] = B_ZERO + 8'($urandom_range(9));
    payload[pos + 1 + digit_count] = $urandom_range(1) ? 8'h00 : 8'h20;
  endtask

  task automatic send_block_head(input logic [7:0] hdr, input logic [7:0] seq,
                                 input logic [7:0] seq_chk);
    send_event(MODE_BYTE, hdr);
    send_event(MODE_BYTE, seq);
    send_event(MODE_BYTE, seq_chk);
  endtask

  task automatic send_block(input logic [7:0] hdr, input logic [7:0] seq, input logic bad_crc);
    int          len;
    logic [15:0] crc;
    len = (hdr == B_STX) ? 1024 : 128;
    crc = 16'h0000;
    send_block_head(hdr, seq, ~seq);
    for (int i = 0; i < len; i++) begin
      crc = crc_update(crc, payload[i]);
      send_event(MODE_BYTE, payload[i]);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
    send_event(MODE_BYTE, crc[15:8]);
    send_event(MODE_BYTE, crc[7:0]);
  endtask

  task automatic test_ignored_events();
    send_event(MODE_BYTE, B_SOH);
    send_event(MODE_TIMEOUT, 8'hFF);
    send_event(MODE_NONE, 8'h00);
    settle();
  endtask

  task automatic test_start_and_eot();
    send_event(MODE_START, 8'hFF);
    send_event(MODE_BYTE, B_EOT);
    send_event(MODE_BYTE, 8'h80);
    send_event(MODE_TIMEOUT, 8'h00);
    send_event(MODE_START, 8'h00);
    send_event(MODE_NONE, 8'hAA);
    send_event(MODE_BYTE, B_EOT);
    settle();
  endtask

  task automatic test_retry_limits();
    write_reg(CFG_RETRY_LIMIT, 25'd1);
    send_event(MODE_START, 8'h5A);
    send_event(MODE_BYTE, 8'h55);
    send_event(MODE_BYTE, B_SOH);
    settle();
    write_reg(CFG_RETRY_LIMIT, 25'd3);
    send_event(MODE_START, 8'hA5);
    send_event(MODE_TIMEOUT, 8'h7F);
    send_block_head(B_SOH, 8'h00, 8'h00);
    send_event(MODE_BYTE, B_STX);
    send_event(MODE_TIMEOUT, 8'h01);
    settle();
    write_reg(CFG_RETRY_LIMIT, 25'd255);
    send_event(MODE_START, 8'h00);
    repeat (4) send_event(MODE_TIMEOUT, 8'($urandom));
    send_event(MODE_BYTE, B_EOT);
    settle();
    write_reg(CFG_RETRY_LIMIT, 25'd10);
  endtask

  task automatic test_info_block();
    send_event(MODE_START, 8'h3C);
    // good block with a nonzero number before block 0: acknowledged and dropped
    fill_random_payload();
    send_block(B_SOH, 8'h05, 1'b0);
    fill_info_payload(5, 3);
    send_block(B_SOH, 8'h00, 1'b1);
    send_block(B_SOH, 8'h00, 1'b0);
    send_event(MODE_BYTE, B_EOT);
    settle();
  endtask

  task automatic test_name_and_size_limits();
    send_event(MODE_START, 8'h00);
    // name runs past the limit with a nonzero byte there
    fill_info_payload(300, 4);
    send_block(B_STX, 8'h00, 1'b1);
    // name exactly at the limit, then more digits than the size field takes
    fill_info_payload(NAME_CHARS, 17);
    send_block(B_STX, 8'h00, 1'b0);
    send_event(MODE_BYTE, B_EOT);
    settle();
    send_event(MODE_START, 8'hFF);
    // empty name; size parsing stops at a letter
    fill_info_payload(0, 4);
    payload[3] = 8'h61;
    send_block(B_SOH, 8'h00, 1'b0);
    send_event(MODE_BYTE, B_EOT);
    settle();
  endtask

  task automatic test_data_transfer();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CFG_BUFFER_LIMIT, 25'd300);
    send_event(MODE_START, 8'h11);
    fill_info_payload(4, 3);
    send_block(B_SOH, 8'h00, 1'b0);
    fill_random_payload();
    send_block(B_SOH, 8'h01, 1'b0);
    send_block_head(B_SOH, 8'h07, 8'hF8);
    send_block_head(B_SOH, 8'h02, 8'h02);
    fill_random_payload();
    send_block(B_SOH, 8'h02, 1'b1);
    send_block(B_SOH, 8'h02, 1'b0);
    // overruns the buffer: writes clamp and the transfer finishes
    fill_random_payload();
    send_block(B_STX, 8'h03, 1'b0);
    send_event(MODE_BYTE, 8'($urandom));
    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure_and_limits();
    write_reg(CFG_BUFFER_LIMIT, BUF_LIMIT_MAX);
    send_event(MODE_START, 8'h00);
    fill_info_payload(2, 2);
    send_block(B_SOH, 8'h00, 1'b0);
    hold_left = 300;
    fill_random_payload();
    send_block(B_SOH, 8'h01, 1'b0);
    settle();
    // limit below what is already committed: nothing more commits
    write_reg(CFG_BUFFER_LIMIT, 25'd100);
    fill_random_payload();
    send_block(B_SOH, 8'h02, 1'b0);
    settle();
    write_reg(CFG_BUFFER_LIMIT, 25'd1);
    send_event(MODE_START, 8'h80);
    fill_info_payload(1, 1);
    send_block(B_SOH, 8'h00, 1'b0);
    fill_random_payload();
    send_block(B_SOH, 8'h01, 1'b0);
    settle();
  endtask

  task automatic test_random_sessions(input int sessions);
    int          pick;
    int          blocks;
    logic [7:0]  hdr;
    logic [7:0]  seq;
    logic [7:0]  other_seq;
    logic [24:0] lim;
    for (int s = 0; s < sessions; s++) begin
      case ($urandom_range(3))
        0: lim = 25'($urandom_range(400, 1));
        1: lim = 25'($urandom_range(1500, 129));
        2: lim = BUF_LIMIT_MAX;
        default: lim = 25'($urandom_range(24'hFFFFFF, 2000));
      endcase
      write_reg(CFG_BUFFER_LIMIT, lim);
      write_reg(CFG_RETRY_LIMIT, $urandom_range(3) == 0 ? 25'($urandom_range(3, 1)) :
                                                          25'($urandom_range(255, 4)));
      sessions_run++;
      send_event(MODE_START, 8'($urandom));
      blocks = $urandom_range(7, 2);
      for (int blk = 0; blk < blocks && rx_phase != PH_DONE; blk++) begin
        pick = $urandom_range(99);
        hdr = ($urandom_range(19) == 0) ? B_STX : B_SOH;
        if (info_done) begin
          seq = seq_expected;
          fill_random_payload();
        end else begin
          seq = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
          fill_info_payload($urandom_range(20), $urandom_range(12));
        end
        if (pick < 68) begin
          send_block(hdr, seq, 1'b0);
        end else if (pick < 76) begin
          send_block(hdr, seq, 1'b1);
        end else if (pick < 82 && info_done) begin
          other_seq = seq + 8'($urandom_range(255, 1));
          send_block_head(hdr, other_seq, ~other_seq);
        end else if (pick < 86) begin
          send_block_head(hdr, seq, seq);
        end else if (pick < 91) begin
          // block cut short by a timeout
          send_block_head(hdr, seq, ~seq);
          for (int i = 0; i < $urandom_range(100); i++) send_event(MODE_BYTE, payload[i]);
          send_event(MODE_TIMEOUT, 8'($urandom));
        end else if (pick < 95) begin
          repeat ($urandom_range(3, 1)) send_event(2'($urandom_range(3, 1)), 8'($urandom));
        end else if (pick < 97) begin
          send_event(MODE_START, 8'($urandom));
        end else begin
          send_event(MODE_TIMEOUT, 8'($urandom));
        end
      end
      if (rx_phase != PH_DONE && $urandom_range(9) != 0) send_event(MODE_BYTE, B_EOT);
      settle();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_NONE;
    rx_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = CFG_BUFFER_LIMIT;
    cfg_data = 25'd0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    limit_bytes = 25'd65536;
    limit_retries = 8'd10;
    clear_session();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ignored_events();
    test_start_and_eot();
    test_retry_limits();
    test_info_block();
    test_name_and_size_limits();
    test_data_transfer();
    test_backpressure_and_limits();
    test_random_sessions(10);
    settle();

    $display("%0d link events sent, %0d result words checked, %0d mismatches", events_sent,
             words_checked, mismatches);
    $display("covered idle/done events, retries and cancel, block 0 parsing, buffer clamping,");
    $display("  output hold-off and %0d random sessions", sessions_run);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
